// ===== rtl/wgk_pkg.sv =====
// Shared types and constants for the weighted Gaussian kernel core.
// Holds the controller/datapath command and status structs, fixed-point
// constants and the reciprocal table for the series division. No dependencies.
`timescale 1ns / 1ps

package wgk_pkg;

    localparam int ACC_W = 21;
    localparam int KV_W  = 17;

    localparam logic [ACC_W-1:0] ACC_MAX      = 21'h1F_FFFF;
    localparam logic [31:0]      ONE_Q31      = 32'h8000_0000;
    localparam logic [29:0]      EXP_NEG1_Q31 = 30'd790015084;
    localparam logic [3:0]       NUM_TERMS    = 4'd12;
    localparam logic [3:0]       K_ONE        = 4'd1;

    // Request type codes.
    localparam logic REQ_WEIGHT = 1'b0;
    localparam logic REQ_PAIR   = 1'b1;

    // At most one command per cycle from the controller to the datapath.
    typedef struct packed {
        logic wr_weight;
        logic load_pair;
        logic accum;
        logic exp_init;
        logic int_step;
        logic term_mul;
        logic term_div;
        logic term_fix;
        logic fin_mul;
        logic fin_out;
    } wgk_cmd_t;

    typedef struct packed {
        logic whole_zero;
        logic last_term;
    } wgk_status_t;

    // floor(2^32 / k) for the series divisors; k of one is bypassed.
    function automatic logic [31:0] recip_q32(input logic [3:0] k);
        logic [31:0] r;
        case (k)
            4'd2:    r = 32'd2147483648;
            4'd3:    r = 32'd1431655765;
            4'd4:    r = 32'd1073741824;
            4'd5:    r = 32'd858993459;
            4'd6:    r = 32'd715827882;
            4'd7:    r = 32'd613566756;
            4'd8:    r = 32'd536870912;
            4'd9:    r = 32'd477218588;
            4'd10:   r = 32'd429496729;
            4'd11:   r = 32'd390451572;
            4'd12:   r = 32'd357913941;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/wgk_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Used for the per-dimension weight table. No dependencies.
`timescale 1ns / 1ps

module wgk_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/wgk_datapath.sv =====
// Datapath of the weighted Gaussian kernel core: weight table, squared
// difference and weighted accumulation, and the exp(-x) series unit.
// Depends on wgk_pkg and wgk_ram; driven by commands from wgk_ctrl.
`timescale 1ns / 1ps

module wgk_datapath import wgk_pkg::*; #(
    parameter int MAX_DIMS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  wgk_cmd_t           cmd,
    input  logic [3:0]         s_dim_index,
    input  logic [23:0]        s_weight_value,
    input  logic signed [23:0] s_a_value,
    input  logic signed [23:0] s_b_value,
    output wgk_status_t        status,
    output logic [KV_W-1:0]    m_kernel_value,
    output logic               m_dim_error
);

    localparam int IDX_W       = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int CNT_W       = $clog2(MAX_DIMS + 1);
    localparam int VALID_DEPTH = 1 << IDX_W;
    localparam logic [CNT_W-1:0] CNT_LIMIT  = CNT_W'(MAX_DIMS);
    localparam logic [6:0]       SLOT_LIMIT = 7'(MAX_DIMS);
    localparam logic [62:0]      HALF_EI    = 63'h4000_0000;
    localparam logic [64:0]      HALF_FIN   = 65'h4000_0000;
    localparam logic [34:0]      HALF_KV    = 35'h4000;

    // State that the reset clears.
    logic [ACC_W-1:0]       acc_reg, acc_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   ovf_reg, ovf_next;
    logic [VALID_DEPTH-1:0] valid_reg, valid_next;

    // Working registers.
    logic [31:0]     sq16_reg;
    logic            inr_reg;
    logic            wvalid_reg;
    logic [4:0]      whole_reg;
    logic [15:0]     frac_reg;
    logic [31:0]     ei_reg;
    logic [31:0]     ef_reg;
    logic [31:0]     t_reg;
    logic [31:0]     p_reg;
    logic [31:0]     q0_reg;
    logic [3:0]      k_reg;
    logic [63:0]     fprod_reg;
    logic            err_reg;
    logic [KV_W-1:0] kv_reg;
    logic            dim_err_reg;

    logic [6:0]       slot_wide;
    logic             slot_ok;
    logic [IDX_W-1:0] slot_idx;
    logic [IDX_W-1:0] cnt_idx;
    logic             in_range;
    logic [23:0]      weight_rd;

    logic [24:0] diff;
    logic [24:0] mag_full;
    logic [23:0] mag;
    logic [47:0] sq_full;

    logic [23:0] w_sel;
    logic [55:0] term_full;
    logic [40:0] sum;

    logic [61:0] ei_prod;
    logic [62:0] ei_rnd;
    logic [47:0] tf_prod;
    logic [63:0] qm_prod;
    logic [35:0] qk_prod;
    logic [31:0] rem;
    logic [31:0] q_fix;
    logic [63:0] f_prod;
    logic [64:0] r_sum;
    logic [34:0] kv_sum;

    assign slot_wide = {3'b000, s_dim_index};
    assign slot_ok   = slot_wide < SLOT_LIMIT;
    assign slot_idx  = slot_wide[IDX_W-1:0];
    assign cnt_idx   = cnt_reg[IDX_W-1:0];
    assign in_range  = cnt_reg < CNT_LIMIT;

    wgk_ram #(
        .WIDTH (24),
        .DEPTH (MAX_DIMS)
    ) u_weight_ram (
        .aclk  (aclk),
        .we    (cmd.wr_weight && slot_ok),
        .waddr (slot_idx),
        .wdata (s_weight_value),
        .raddr (cnt_idx),
        .rdata (weight_rd)
    );

    // Squared difference, taken on the accepting edge.
    assign diff     = {s_a_value[23], s_a_value} - {s_b_value[23], s_b_value};
    assign mag_full = diff[24] ? (~diff + 25'd1) : diff;
    assign mag      = mag_full[23:0];
    assign sq_full  = mag * mag;

    // Weighted term and saturating accumulation.
    assign w_sel     = wvalid_reg ? weight_rd : 24'd0;
    assign term_full = w_sel * sq16_reg;
    assign sum       = {20'd0, acc_reg} + {1'b0, term_full[55:16]};

    // Exponential series arithmetic.
    assign ei_prod = ei_reg * EXP_NEG1_Q31;
    assign ei_rnd  = {1'b0, ei_prod} + HALF_EI;
    assign tf_prod = t_reg * frac_reg;
    assign qm_prod = p_reg * recip_q32(k_reg);
    assign qk_prod = q0_reg * k_reg;
    assign rem     = p_reg - qk_prod[31:0];
    assign q_fix   = (rem >= {28'd0, k_reg}) ? (q0_reg + 32'd1) : q0_reg;
    assign f_prod  = ei_reg * ef_reg;
    assign r_sum   = {1'b0, fprod_reg} + HALF_FIN;
    assign kv_sum  = {1'b0, r_sum[64:31]} + HALF_KV;

    always_comb begin
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        ovf_next   = ovf_reg;
        valid_next = valid_reg;
        if (cmd.wr_weight && slot_ok) begin
            valid_next[slot_idx] = 1'b1;
        end
        if (cmd.load_pair && !in_range) begin
            ovf_next = 1'b1;
        end
        if (cmd.accum && inr_reg) begin
            acc_next = (sum > {20'd0, ACC_MAX}) ? ACC_MAX : sum[ACC_W-1:0];
            cnt_next = cnt_reg + CNT_W'(1);
        end
        if (cmd.exp_init) begin
            acc_next = '0;
            cnt_next = '0;
            ovf_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg   <= '0;
            cnt_reg   <= '0;
            ovf_reg   <= 1'b0;
            valid_reg <= '0;
        end else begin
            acc_reg   <= acc_next;
            cnt_reg   <= cnt_next;
            ovf_reg   <= ovf_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_pair) begin
            sq16_reg   <= sq_full[47:16];
            inr_reg    <= in_range;
            wvalid_reg <= in_range && valid_reg[cnt_idx];
        end
        if (cmd.exp_init) begin
            whole_reg <= acc_reg[ACC_W-1:16];
            frac_reg  <= acc_reg[15:0];
            ei_reg    <= ONE_Q31;
            ef_reg    <= ONE_Q31;
            t_reg     <= ONE_Q31;
            k_reg     <= K_ONE;
            err_reg   <= ovf_reg;
        end
        if (cmd.int_step) begin
            ei_reg    <= ei_rnd[62:31];
            whole_reg <= whole_reg - 5'd1;
        end
        if (cmd.term_mul) begin
            p_reg <= tf_prod[47:16];
        end
        if (cmd.term_div) begin
            q0_reg <= (k_reg == K_ONE) ? p_reg : qm_prod[63:32];
        end
        if (cmd.term_fix) begin
            t_reg  <= q_fix;
            ef_reg <= k_reg[0] ? (ef_reg - q_fix) : (ef_reg + q_fix);
            k_reg  <= k_reg + 4'd1;
        end
        if (cmd.fin_mul) begin
            fprod_reg <= f_prod;
        end
        if (cmd.fin_out) begin
            kv_reg      <= kv_sum[31:15];
            dim_err_reg <= err_reg;
        end
    end

    assign status.whole_zero = (whole_reg == 5'd0);
    assign status.last_term  = (k_reg == NUM_TERMS);
    assign m_kernel_value    = kv_reg;
    assign m_dim_error       = dim_err_reg;

endmodule

// ===== rtl/wgk_ctrl.sv =====
// Controller of the weighted Gaussian kernel core: input and result
// handshakes and the sequence of datapath commands. Depends on wgk_pkg.
`timescale 1ns / 1ps

module wgk_ctrl import wgk_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_req_type,
    input  logic        s_last,
    input  logic        m_ready,
    input  wgk_status_t status,
    output logic        s_ready,
    output logic        m_valid,
    output wgk_cmd_t    cmd
);

    typedef enum logic [8:0] {
        ST_IDLE     = 9'b000000001,
        ST_PAIR     = 9'b000000010,
        ST_EXP_INIT = 9'b000000100,
        ST_EXP_INT  = 9'b000001000,
        ST_TERM_MUL = 9'b000010000,
        ST_TERM_DIV = 9'b000100000,
        ST_TERM_FIX = 9'b001000000,
        ST_FIN_MUL  = 9'b010000000,
        ST_FIN_OUT  = 9'b100000000
    } wgk_state_t;

    wgk_state_t state_reg, state_next;
    logic       last_reg, last_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign out_free = !out_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = out_valid_reg;

    always_comb begin
        state_next     = state_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && !m_ready;
        cmd            = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_req_type == REQ_WEIGHT) begin
                        cmd.wr_weight = 1'b1;
                    end else begin
                        cmd.load_pair = 1'b1;
                        last_next     = s_last;
                        state_next    = ST_PAIR;
                    end
                end
            end
            ST_PAIR: begin
                cmd.accum  = 1'b1;
                state_next = last_reg ? ST_EXP_INIT : ST_IDLE;
            end
            ST_EXP_INIT: begin
                cmd.exp_init = 1'b1;
                state_next   = ST_EXP_INT;
            end
            ST_EXP_INT: begin
                if (status.whole_zero) begin
                    state_next = ST_TERM_MUL;
                end else begin
                    cmd.int_step = 1'b1;
                end
            end
            ST_TERM_MUL: begin
                cmd.term_mul = 1'b1;
                state_next   = ST_TERM_DIV;
            end
            ST_TERM_DIV: begin
                cmd.term_div = 1'b1;
                state_next   = ST_TERM_FIX;
            end
            ST_TERM_FIX: begin
                cmd.term_fix = 1'b1;
                state_next   = status.last_term ? ST_FIN_MUL : ST_TERM_MUL;
            end
            ST_FIN_MUL: begin
                cmd.fin_mul = 1'b1;
                state_next  = ST_FIN_OUT;
            end
            ST_FIN_OUT: begin
                // Wait here until the result register has been emptied.
                if (out_free) begin
                    cmd.fin_out    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/weighted_gaussian_kernel_core.sv =====
// Top level of the weighted Gaussian kernel core, exp(-sum w_k*(a_k-b_k)^2).
// Joins wgk_ctrl and wgk_datapath (with its wgk_ram weight table); uses wgk_pkg.
//
//   Channel  Direction  Handshake          Payload
//   s_       in         s_valid/s_ready    req_type, dim_index, weight_value,
//                                          a_value, b_value, last
//   m_       out        m_valid/m_ready    kernel_value, dim_error
//
// A weight write is stored on the accepting edge. A component pair is squared
// on the accepting edge, then weight-multiplied and accumulated. A pair marked
// last then evaluates exp(-x): one multiplier step per factor of exp(-1), i of
// them, where i is the integer part of the accumulated distance (0 to 31), then
// a multiply, a divide and a correction for each of the twelve series terms.
// Reset clears the weight table valid bits and the accumulator.
// A waiting result does not stall input; only the next result waits for it.
`timescale 1ns / 1ps

module weighted_gaussian_kernel_core import wgk_pkg::*; #(
    parameter int MAX_DIMS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_req_type,
    input  logic [3:0]         s_dim_index,
    input  logic [23:0]        s_weight_value,
    input  logic signed [23:0] s_a_value,
    input  logic signed [23:0] s_b_value,
    input  logic               s_last,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [KV_W-1:0]    m_kernel_value,
    output logic               m_dim_error
);

    wgk_cmd_t    ctrl_cmd;
    wgk_status_t dp_status;

    wgk_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_req_type (s_req_type),
        .s_last     (s_last),
        .m_ready    (m_ready),
        .status     (dp_status),
        .s_ready    (s_ready),
        .m_valid    (m_valid),
        .cmd        (ctrl_cmd)
    );

    wgk_datapath #(
        .MAX_DIMS (MAX_DIMS)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (ctrl_cmd),
        .s_dim_index    (s_dim_index),
        .s_weight_value (s_weight_value),
        .s_a_value      (s_a_value),
        .s_b_value      (s_b_value),
        .status         (dp_status),
        .m_kernel_value (m_kernel_value),
        .m_dim_error    (m_dim_error)
    );

    // The controller issues at most one datapath command per cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(ctrl_cmd))
        else $error("More than one datapath command in a cycle.");

    // Weight and pair commands only come with an accepted transaction.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl_cmd.wr_weight || ctrl_cmd.load_pair) |-> (s_valid && s_ready))
        else $error("Input command without an accepted transaction.");

    // Loading the result register presents a result on the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl_cmd.fin_out |=> m_valid)
        else $error("Result loaded but not presented.");

    // The kernel value never exceeds one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_kernel_value <= 17'd65536))
        else $error("Kernel value above one.");

endmodule

// ===== test/tb_weighted_gaussian_kernel_core.sv =====
// Self-checking testbench for weighted_gaussian_kernel_core: directed and random
// weight writes and component-pair vectors, each result checked against a local predictor.
// Depends on wgk_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb_weighted_gaussian_kernel_core;
    import wgk_pkg::*;

    localparam int DIMS         = 16;
    localparam int MAX_GAP      = 14;
    localparam int TAIL_CYCLES  = 120;
    localparam int RANDOM_ITEMS = 1780;

    typedef struct {
        logic [KV_W-1:0] kernel;
        logic            dim_err;
    } kernel_result_t;

    logic              aclk           = 1'b0;
    logic              aresetn        = 1'b0;
    logic              s_valid        = 1'b0;
    logic              s_ready;
    logic              s_req_type     = REQ_WEIGHT;
    logic [3:0]        s_dim_index    = '0;
    logic [23:0]       s_weight_value = '0;
    logic signed [23:0] s_a_value     = '0;
    logic signed [23:0] s_b_value     = '0;
    logic              s_last         = 1'b0;
    logic              m_valid;
    logic              m_ready        = 1'b0;
    logic [KV_W-1:0]   m_kernel_value;
    logic              m_dim_error;

    // Predictor state.
    logic [23:0]       weight_copy [DIMS];
    logic [ACC_W-1:0]  dist_acc;
    int                pair_count;
    logic              excess_seen;
    kernel_result_t    pending_kernels [$];

    int mismatches = 0;
    int items_sent = 0;
    bit quiet      = 1'b0;

    weighted_gaussian_kernel_core #(
        .MAX_DIMS(DIMS)
    ) uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_dim_index   (s_dim_index),
        .s_weight_value(s_weight_value),
        .s_a_value     (s_a_value),
        .s_b_value     (s_b_value),
        .s_last        (s_last),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kernel_value(m_kernel_value),
        .m_dim_error   (m_dim_error)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // exp(-acc) in Q1.16: integer part by repeated multiplication with exp(-1),
    // fractional part by a twelve-term Taylor series, all in Q1.31.
    function automatic logic [KV_W-1:0] exp_neg_q16(input logic [ACC_W-1:0] acc);
        logic [63:0] ei;
        logic [63:0] ef;
        logic [63:0] t;
        logic [63:0] frac;
        logic [63:0] r;
        int          whole;
        ei    = 64'(ONE_Q31);
        ef    = ei;
        t     = ei;
        whole = int'(acc[ACC_W-1:16]);
        frac  = 64'(acc[15:0]);
        for (int k = 0; k < whole; k++) begin
            ei = (ei * 64'(EXP_NEG1_Q31) + 64'h4000_0000) >> 31;
        end
        for (int k = 1; k <= int'(NUM_TERMS); k++) begin
            t = ((t * frac) >> 16) / 64'(k);
            if (k % 2 == 1) begin
                ef = ef - t;
            end else begin
                ef = ef + t;
            end
        end
        r = (ei * ef + 64'h4000_0000) >> 31;
        return KV_W'((r + 64'h4000) >> 15);
    endfunction

    function automatic void predict_item(input logic req, input logic [3:0] idx,
                                         input logic [23:0] w, input logic signed [23:0] a,
                                         input logic signed [23:0] b, input logic last);
        longint         diff;
        logic [63:0]    mag;
        logic [63:0]    term;
        logic [63:0]    sum;
        kernel_result_t res;
        if (req == REQ_WEIGHT) begin
            if (int'(idx) < DIMS) begin
                weight_copy[idx] = w;
            end
            return;
        end
        if (pair_count < DIMS) begin
            diff = longint'(a) - longint'(b);
            mag  = (diff < 0) ? 64'(-diff) : 64'(diff);
            term = (64'(weight_copy[pair_count]) * ((mag * mag) >> 16)) >> 16;
            sum  = 64'(dist_acc) + term;
            dist_acc = (sum > 64'(ACC_MAX)) ? ACC_MAX : sum[ACC_W-1:0];
            pair_count++;
        end else begin
            excess_seen = 1'b1;
        end
        if (last) begin
            res.kernel  = exp_neg_q16(dist_acc);
            res.dim_err = excess_seen;
            pending_kernels.push_back(res);
            dist_acc    = '0;
            pair_count  = 0;
            excess_seen = 1'b0;
        end
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] ERROR: %s", $time, what);
        mismatches++;
    endtask

    // Drives one input transaction after a random gap (none when quiet) and waits for its acceptance.
    task automatic send_item(input logic req, input logic [3:0] idx, input logic [23:0] w,
                             input logic [23:0] a, input logic [23:0] b, input logic last);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
        @(negedge aclk);
        if (gap != 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_req_type     = req;
        s_dim_index    = idx;
        s_weight_value = w;
        s_a_value      = a;
        s_b_value      = b;
        s_last         = last;
        s_valid        = 1'b1;
        do @(posedge aclk); while (s_ready !== 1'b1);
        predict_item(req, idx, w, a, b, last);
        items_sent++;
    endtask

    // Unused payload fields carry random values so that their bits toggle as well.
    task automatic write_weight(input logic [3:0] idx, input logic [23:0] w, input logic last);
        send_item(REQ_WEIGHT, idx, w, 24'($urandom()), 24'($urandom()), last);
    endtask

    task automatic send_pair(input logic [23:0] a, input logic [23:0] b, input logic last);
        send_item(REQ_PAIR, 4'($urandom()), 24'($urandom()), a, b, last);
    endtask

    function automatic logic [23:0] random_weight();
        case ($urandom_range(0, 3))
            0:       return 24'($urandom());
            1:       return $urandom_range(0, 1) ? 24'hFF_FFFF : 24'h00_0000;
            default: return 24'($urandom_range(0, 24'h04_0000));
        endcase
    endfunction

    // No slot has been written since reset, so every weight reads as zero and the result must be exactly one.
    task automatic test_unwritten_weights();
        send_pair(24'h7F_FFFF, 24'h80_0000, 1'b1);
    endtask

    task automatic test_extreme_values();
        write_weight(4'd0, 24'hFF_FFFF, 1'b0);
        // The last flag on a weight write must not produce a result.
        write_weight(4'd1, 24'h00_0001, 1'b1);
        send_pair(24'h00_0000, 24'h00_0000, 1'b0);
        send_pair(24'h7F_FFFF, 24'h80_0000, 1'b1);
        // Full weight with the widest difference drives the accumulator into saturation.
        send_pair(24'h80_0000, 24'h7F_FFFF, 1'b1);
    endtask

    // Seventeen pairs: the last one is dropped, flags the error and still yields a result.
    task automatic test_excess_pairs();
        write_weight(4'd15, 24'h00_8000, 1'b0);
        for (int i = 0; i <= DIMS; i++) begin
            send_pair(24'($urandom_range(0, 24'h02_0000)) - 24'h01_0000,
                      24'($urandom_range(0, 24'h02_0000)) - 24'h01_0000, i == DIMS);
        end
    endtask

    task automatic test_random_vectors(input int item_budget);
        int          stop_at;
        int          vec_len;
        int          style;
        int          loads;
        logic [23:0] a;
        logic [23:0] b;
        logic [23:0] delta;
        stop_at = items_sent + item_budget;
        while (items_sent < stop_at) begin
            quiet = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 2) == 0) begin
                loads = $urandom_range(1, DIMS);
                repeat (loads) write_weight(4'($urandom()), random_weight(), 1'($urandom()));
            end
            vec_len = ($urandom_range(0, 9) == 0) ? $urandom_range(DIMS + 1, DIMS + 4)
                                                  : $urandom_range(1, DIMS);
            style = $urandom_range(0, 5);
            for (int i = 0; i < vec_len; i++) begin
                if ($urandom_range(0, 19) == 0) begin
                    write_weight(4'($urandom()), random_weight(), 1'($urandom()));
                end
                a = 24'($urandom());
                case (style)
                    0: begin
                        b = 24'($urandom());
                    end
                    1: begin
                        b = a;
                    end
                    default: begin
                        // Small differences keep the distance in the useful range of exp.
                        delta = 24'($urandom_range(0, 24'h00_C000));
                        b = $urandom_range(0, 1) ? a + delta : a - delta;
                    end
                endcase
                send_pair(a, b, i == vec_len - 1);
            end
        end
        quiet = 1'b0;
    endtask

    // Result side: random stall (none when quiet) before each transaction, then field-by-field comparison.
    always begin : result_sink
        int             stall;
        kernel_result_t want;
        @(negedge aclk);
        stall = quiet ? 0 : $urandom_range(0, MAX_GAP);
        if (stall != 0) begin
            m_ready = 1'b0;
            repeat (stall) @(negedge aclk);
        end
        m_ready = 1'b1;
        do @(posedge aclk); while (m_valid !== 1'b1 || aresetn !== 1'b1);
        if (pending_kernels.size() == 0) begin
            report_mismatch($sformatf("result with none expected: kernel_value=%0d dim_error=%0d",
                                      m_kernel_value, m_dim_error));
        end else begin
            want = pending_kernels.pop_front();
            if (m_kernel_value !== want.kernel) begin
                report_mismatch($sformatf("kernel_value got %0d expected %0d",
                                          m_kernel_value, want.kernel));
            end
            if (m_dim_error !== want.dim_err) begin
                report_mismatch($sformatf("dim_error got %0d expected %0d",
                                          m_dim_error, want.dim_err));
            end
        end
    end

    initial begin
        for (int i = 0; i < DIMS; i++) begin
            weight_copy[i] = '0;
        end
        dist_acc    = '0;
        pair_count  = 0;
        excess_seen = 1'b0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_unwritten_weights();
        test_extreme_values();
        test_excess_pairs();
        test_random_vectors(RANDOM_ITEMS);

        @(negedge aclk);
        s_valid = 1'b0;
        while (pending_kernels.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("weighted_gaussian_kernel_core test passed");
        end else begin
            $display("weighted_gaussian_kernel_core test failed");
        end
        $finish;
    end

    // Far beyond the slowest legal run: every transaction with maximal gaps and
    // the longest exponential evaluation.
    initial begin
        #20_000_000;
        $display("weighted_gaussian_kernel_core test failed");
        $finish;
    end

endmodule
